/* sv/complex_arith_unit_assert.svh */
// Assertion macros shared by the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAU_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cau_pkg.sv */
// Types, codes and helper functions of the complex arithmetic unit.
package cau_pkg;

    localparam int QUO_W = 33;
    localparam int DIV_STAGES = 33;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_SQR = 3'd4,
        ACT_ABS = 3'd5
    } action_t;

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } sat_t;

    // One lane of the restoring divider.
    typedef struct packed {
        logic               neg;
        logic               cap;
        logic [63:0]        rem;
        logic [63:0]        num;
        logic [QUO_W-1:0]   quo;
    } div_lane_t;

    typedef struct packed {
        logic        valid;
        logic        is_div;
        logic        dbz;
        logic [31:0] re;
        logic [31:0] im;
        logic        ovf;
        div_lane_t   lre;
        div_lane_t   lim;
        logic [63:0] den;
    } pipe_t;

    function automatic sat_t sat65(input logic signed [64:0] v);
        sat_t r;
        r.ovf = 1'b0;
        r.val = v[31:0];
        if (v > 65'sh0_7FFF_FFFF) begin
            r.val = 32'h7FFF_FFFF;
            r.ovf = 1'b1;
        end else if (v < -65'sh0_8000_0000) begin
            r.val = 32'h8000_0000;
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    // Saturate a sign and a 34-bit magnitude to 32-bit two's complement.
    function automatic sat_t pack_mag(input logic neg, input logic [33:0] mag);
        sat_t        r;
        logic [33:0] negv;
        negv  = 34'd0 - mag;
        r.ovf = 1'b0;
        r.val = mag[31:0];
        if (!neg) begin
            if (mag > 34'h0_7FFF_FFFF) begin
                r.val = 32'h7FFF_FFFF;
                r.ovf = 1'b1;
            end
        end else if (mag > 34'h0_8000_0000) begin
            r.val = 32'h8000_0000;
            r.ovf = 1'b1;
        end else begin
            r.val = negv[31:0];
        end
        return r;
    endfunction

    function automatic div_lane_t div_step(input div_lane_t l, input logic nb,
                                           input logic [63:0] d);
        div_lane_t   r;
        logic [64:0] trial;
        logic        ge;
        trial = {l.rem, nb};
        ge    = (trial >= {1'b0, d});
        r     = l;
        if (ge) begin
            trial = trial - {1'b0, d};
        end
        r.rem = trial[63:0];
        r.quo = {l.quo[QUO_W-2:0], ge};
        return r;
    endfunction

endpackage

/* sv/complex_arith_unit.sv */
// Top level of the complex arithmetic unit.
//
//  channel  | direction | contents
//  s_ beat  | in        | tuser: action; tdata: a_re, a_im, b_re, b_im
//  m_ beat  | out       | tdata: res_re, res_im; tuser: overflow, divide_by_zero
//
// Every beat passes through three front stages,
// 33 divider stages (one quotient bit each), and the output register.
// One beat enters per cycle unless the output register is held; the whole pipeline advances together.
// A held output register stalls every stage, so nothing is lost or repeated.
// Reset clears the valid bits of all stages.
module complex_arith_unit #(
    parameter int FRAC_BITS = 28
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [2:0]    s_tuser,   // action
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // res_re, res_im
    output logic [1:0]    m_tuser    // overflow, divide_by_zero
);

    logic            en;
    cau_pkg::pipe_t  front_out, div_out;
    cau_pkg::sat_t   q_re, q_im;
    logic            m_valid_reg;
    logic [63:0]     m_data_reg, m_data_next;
    logic [1:0]      m_user_reg, m_user_next;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .action   (s_tuser),
        .a_re     (s_tdata[31:0]),
        .a_im     (s_tdata[63:32]),
        .b_re     (s_tdata[95:64]),
        .b_im     (s_tdata[127:96]),
        .out      (front_out)
    );

    cau_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in      (front_out),
        .out     (div_out)
    );

    always_comb begin
        q_re = cau_pkg::pack_mag(div_out.lre.neg,
                   div_out.lre.cap ? 34'h2_0000_0000 : {1'b0, div_out.lre.quo});
        q_im = cau_pkg::pack_mag(div_out.lim.neg,
                   div_out.lim.cap ? 34'h2_0000_0000 : {1'b0, div_out.lim.quo});
        if (div_out.is_div && div_out.dbz) begin
            m_data_next = 64'd0;
            m_user_next = 2'b10;
        end else if (div_out.is_div) begin
            m_data_next = {q_im.val, q_re.val};
            m_user_next = {1'b0, q_re.ovf | q_im.ovf};
        end else begin
            m_data_next = {div_out.im, div_out.re};
            m_user_next = {1'b0, div_out.ovf};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`include "complex_arith_unit_assert.svh"

    // A zero divisor gives a zero result without overflow.
    `CAU_ASSERT_SAME(a_dbz_zero, aclk, aresetn, m_tvalid && m_tuser[1], (m_tdata == 64'd0) && !m_tuser[0], "divide by zero beat not cleared")
    // Overflow means one part sits at a limit.
    `CAU_ASSERT_SAME(a_ovf_limit, aclk, aresetn, m_tvalid && m_tuser[0], (m_tdata[31:0] == 32'h7FFF_FFFF) || (m_tdata[31:0] == 32'h8000_0000) || (m_tdata[63:32] == 32'h7FFF_FFFF) || (m_tdata[63:32] == 32'h8000_0000), "overflow without saturated part")
    // A stalled output holds its result.
    `CAU_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

/* sv/cau_front.sv */
// Front end: products, exact sums, and the non-divide results.
module cau_front #(
    parameter int FRAC_BITS = 28
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [2:0]           action,
    input  logic signed [31:0]   a_re,
    input  logic signed [31:0]   a_im,
    input  logic signed [31:0]   b_re,
    input  logic signed [31:0]   b_im,
    output cau_pkg::pipe_t       out
);

    localparam int PRE_SHIFT = 33 - FRAC_BITS;

    // Stage 1: products.
    logic                v1_reg;
    logic [2:0]          act1_reg;
    logic signed [31:0]  ar1_reg, br1_reg, ai1_reg, bi1_reg;
    logic signed [63:0]  prr1_reg, pii1_reg, pri1_reg, pir1_reg, pbr1_reg, pbi1_reg;
    logic signed [31:0]  bre_sel, bim_sel;

    always_comb begin
        if (cau_pkg::action_t'(action) == cau_pkg::ACT_SQR) begin
            bre_sel = a_re;
            bim_sel = a_im;
        end else begin
            bre_sel = b_re;
            bim_sel = b_im;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act1_reg <= action;
            ar1_reg  <= a_re;
            br1_reg  <= bre_sel;
            ai1_reg  <= a_im;
            bi1_reg  <= bim_sel;
            prr1_reg <= 64'(a_re) * 64'(bre_sel);
            pii1_reg <= 64'(a_im) * 64'(bim_sel);
            pri1_reg <= 64'(a_re) * 64'(bim_sel);
            pir1_reg <= 64'(a_im) * 64'(bre_sel);
            pbr1_reg <= 64'(bre_sel) * 64'(bre_sel);
            pbi1_reg <= 64'(bim_sel) * 64'(bim_sel);
        end
    end

    // Stage 2: exact sums.
    logic                v2_reg;
    logic [2:0]          act2_reg;
    logic signed [64:0]  mre2_reg, mim2_reg, dre2_reg, dim2_reg;
    logic [63:0]         den2_reg;
    logic signed [32:0]  as2_reg, asi2_reg, abs2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act2_reg <= act1_reg;
            mre2_reg <= 65'(prr1_reg) - 65'(pii1_reg);
            mim2_reg <= 65'(pri1_reg) + 65'(pir1_reg);
            dre2_reg <= 65'(prr1_reg) + 65'(pii1_reg);
            dim2_reg <= 65'(pir1_reg) - 65'(pri1_reg);
            den2_reg <= 64'(pbr1_reg) + 64'(pbi1_reg);
            if (cau_pkg::action_t'(act1_reg) == cau_pkg::ACT_SUB) begin
                as2_reg  <= 33'(ar1_reg) - 33'(br1_reg);
                asi2_reg <= 33'(ai1_reg) - 33'(bi1_reg);
            end else begin
                as2_reg  <= 33'(ar1_reg) + 33'(br1_reg);
                asi2_reg <= 33'(ai1_reg) + 33'(bi1_reg);
            end
            if (ar1_reg < 0) begin
                abs2_reg <= -33'(ar1_reg);
            end else begin
                abs2_reg <= 33'(ar1_reg);
            end
        end
    end

    // Stage 3: saturate the simple results and set up the divider lanes.
    cau_pkg::pipe_t      p3_next, p3_reg;
    cau_pkg::sat_t       s_re, s_im;
    logic                nre_neg, nim_neg;
    logic [63:0]         nre_mag, nim_mag;
    logic signed [64:0]  neg_re, neg_im;

    always_comb begin
        neg_re  = -dre2_reg;
        neg_im  = -dim2_reg;
        nre_neg = dre2_reg[64];
        nim_neg = dim2_reg[64];
        nre_mag = nre_neg ? neg_re[63:0] : dre2_reg[63:0];
        nim_mag = nim_neg ? neg_im[63:0] : dim2_reg[63:0];
        s_re    = '0;
        s_im    = '0;
        p3_next = '0;
        p3_next.valid = v2_reg;
        p3_next.den   = den2_reg;
        unique case (act2_reg)
            cau_pkg::ACT_ADD, cau_pkg::ACT_SUB: begin
                s_re = cau_pkg::sat65(65'(as2_reg));
                s_im = cau_pkg::sat65(65'(asi2_reg));
            end
            cau_pkg::ACT_MUL, cau_pkg::ACT_SQR: begin
                s_re = cau_pkg::sat65(mre2_reg >>> FRAC_BITS);
                s_im = cau_pkg::sat65(mim2_reg >>> FRAC_BITS);
            end
            cau_pkg::ACT_ABS: begin
                s_re = cau_pkg::sat65(65'(abs2_reg));
            end
            cau_pkg::ACT_DIV: begin
                p3_next.is_div = 1'b1;
                p3_next.dbz    = (den2_reg == 64'd0);
            end
            default: begin
            end
        endcase
        p3_next.re      = s_re.val;
        p3_next.im      = s_im.val;
        p3_next.ovf     = s_re.ovf | s_im.ovf;
        p3_next.lre.neg = nre_neg;
        p3_next.lre.num = nre_mag;
        p3_next.lre.rem = nre_mag >> PRE_SHIFT;
        p3_next.lre.cap = ((nre_mag >> PRE_SHIFT) >= den2_reg);
        p3_next.lim.neg = nim_neg;
        p3_next.lim.num = nim_mag;
        p3_next.lim.rem = nim_mag >> PRE_SHIFT;
        p3_next.lim.cap = ((nim_mag >> PRE_SHIFT) >= den2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_reg.valid <= 1'b0;
        end else if (en) begin
            p3_reg <= p3_next;
        end
    end

    assign out = p3_reg;

endmodule

/* sv/cau_divider.sv */
// Pipelined restoring divider: one quotient bit per stage for both lanes.
module cau_divider #(
    parameter int FRAC_BITS = 28
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  cau_pkg::pipe_t  in,
    output cau_pkg::pipe_t  out
);

    cau_pkg::pipe_t st_reg [cau_pkg::DIV_STAGES];

    for (genvar g = 0; g < cau_pkg::DIV_STAGES; g++) begin : g_stage
        localparam int K = cau_pkg::DIV_STAGES - 1 - g;
        cau_pkg::pipe_t src, st_next;
        logic           bre, bim;

        if (g == 0) begin : g_first
            assign src = in;
        end else begin : g_rest
            assign src = st_reg[g-1];
        end

        // Bits of the numerator scaled by 2^FRAC_BITS; the low ones are zero.
        if (K >= FRAC_BITS) begin : g_nbit
            assign bre = src.lre.num[K-FRAC_BITS];
            assign bim = src.lim.num[K-FRAC_BITS];
        end else begin : g_zero
            assign bre = 1'b0;
            assign bim = 1'b0;
        end

        always_comb begin
            st_next     = src;
            st_next.lre = cau_pkg::div_step(src.lre, bre, src.den);
            st_next.lim = cau_pkg::div_step(src.lim, bim, src.den);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_reg[g].valid <= 1'b0;
            end else if (en) begin
                st_reg[g] <= st_next;
            end
        end
    end

    assign out = st_reg[cau_pkg::DIV_STAGES-1];

endmodule
